FILE: rtl/lft_pkg.sv
package lft_pkg;

  localparam int CFG_W    = 5;
  localparam int CFG_IX_W = 1;
  localparam int ADDR_W   = 32;
  localparam int PAGE_W   = 32;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [CFG_IX_W-1:0] CFG_PAGE_SHIFT = 1'd0;
  localparam logic [CFG_IX_W-1:0] CFG_FRAMES     = 1'd1;

  localparam logic [CFG_W-1:0] PAGE_SHIFT_RST = 5'd12;
  localparam logic [CFG_W-1:0] FRAMES_RST     = 5'd16;

  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_TERM   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FILLED  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_APPEND  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REPLACE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TERM    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic in_stall;
    logic scan_issue;
    logic commit;
    logic deliver;
  } ctrl_t;

endpackage

FILE: rtl/lft_entry_ram.sv
module lft_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lru_frame_table.sv
// Channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_stall  | req_type, owner_id, address
// out      | out_valid / out_stall| status, frame_index, page_number,
//          |                      | freed_count
// cfg      | cfg_we               | cfg_index, cfg_data
//
// A beat is taken only in idle. Its result is offered after the walk, which
// reads one RAM entry a cycle through the registered RAM read port, then the
// commit state and the delivery state; delivery waits while a result is held.
// The next beat is taken the cycle after delivery at the earliest.
// rst (synchronous) resets fill count, freed bits, stamp counter and config;
// the RAM is not cleared. A held result stalls only delivery of the next one.
module lru_frame_table #(
  parameter int NUM_FRAMES = 16,
  parameter int OWNER_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [lft_pkg::CFG_IX_W-1:0]             cfg_index,
  input  logic [lft_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     req_type,
  input  logic [OWNER_BITS-1:0]                    owner_id,
  input  logic [lft_pkg::ADDR_W-1:0]               address,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [lft_pkg::STATUS_W-1:0]             status,
  output logic [$clog2(NUM_FRAMES)-1:0]            frame_index,
  output logic [lft_pkg::PAGE_W-1:0]               page_number,
  output logic [$clog2(NUM_FRAMES+1)-1:0]          freed_count
);

  import lft_pkg::*;

  localparam int IDX_W  = $clog2(NUM_FRAMES);
  localparam int FILL_W = $clog2(NUM_FRAMES + 1);
  localparam int LIM_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int ENT_W  = PAGE_W + OWNER_BITS + STAMP_W;
  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(NUM_FRAMES);

  // config
  logic [CFG_W-1:0] page_shift;
  logic [CFG_W-1:0] frames_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift    <= PAGE_SHIFT_RST;
      frames_in_use <= FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_SHIFT: page_shift    <= cfg_data;
        CFG_FRAMES:     frames_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  state_t state, state_next;
  ctrl_t  ctrl;

  logic [FILL_W-1:0]   fill_count;
  logic [NUM_FRAMES-1:0] entry_freed;
  logic [STAMP_W-1:0]  stamp_counter;

  // request held for the walk
  logic                  req_q;
  logic [OWNER_BITS-1:0] owner_q;
  logic [PAGE_W-1:0]     page_q;

  // walk
  logic [FILL_W-1:0] scan_addr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [ENT_W-1:0]  rd_data;
  logic [PAGE_W-1:0]     rd_page;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  rd_freed;
  logic                  scan_done;

  logic                  have_fr, have_hit, have_best;
  logic [IDX_W-1:0]      fr_idx, hit_idx, best_idx;
  logic [OWNER_BITS-1:0] hit_owner;
  logic [STAMP_W-1:0]    best_stamp;
  logic [FILL_W-1:0]     freed_cnt;

  // result staging
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_frame;
  logic [PAGE_W-1:0]   res_page;
  logic [FILL_W-1:0]   res_freed;

  logic out_free;
  logic in_take;

  assign out_free  = !out_valid || !out_stall;
  assign in_take   = in_valid && !in_stall;
  assign scan_done = (scan_addr >= fill_count) && !rd_vld;

  assign {rd_page, rd_owner, rd_stamp} = rd_data;
  assign rd_freed = entry_freed[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SCAN;
      ST_SCAN:    if (scan_done) state_next = ST_COMMIT;
      ST_COMMIT:  state_next = ST_DELIVER;
      ST_DELIVER: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:    ctrl.in_stall = 1'b0;
      ST_SCAN: begin
        ctrl.in_stall   = 1'b1;
        ctrl.scan_issue = scan_addr < fill_count;
      end
      ST_COMMIT: begin
        ctrl.in_stall = 1'b1;
        ctrl.commit   = 1'b1;
      end
      ST_DELIVER: begin
        ctrl.in_stall = 1'b1;
        ctrl.deliver  = out_free;
      end
      default:    ctrl.in_stall = 1'b1;
    endcase
  end

  assign in_stall = ctrl.in_stall;

  // capture request; page is computed up front
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_q   <= req_type;
      owner_q <= owner_id;
      page_q  <= (req_type == REQ_TERM) ? '0 : (address >> page_shift);
    end
  end

  // read issue, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      scan_addr <= '0;
    end else if (in_take) begin
      rd_vld    <= 1'b0;
      scan_addr <= '0;
    end else begin
      rd_vld <= ctrl.scan_issue;
      if (ctrl.scan_issue) begin
        rd_idx    <= scan_addr[IDX_W-1:0];
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  // per-entry evaluation of returned read data
  always_ff @(posedge clk) begin
    if (in_take) begin
      have_fr   <= 1'b0;
      have_hit  <= 1'b0;
      have_best <= 1'b0;
      freed_cnt <= '0;
    end else if (rd_vld) begin
      if (req_q == REQ_TERM) begin
        if (!rd_freed && rd_owner == owner_q) freed_cnt <= freed_cnt + 1'b1;
      end else begin
        if (rd_freed && !have_fr) begin
          have_fr <= 1'b1;
          fr_idx  <= rd_idx;
        end
        if (!rd_freed && !have_hit && rd_page == page_q) begin
          have_hit  <= 1'b1;
          hit_idx   <= rd_idx;
          hit_owner <= rd_owner;
        end
        // strict compare keeps the lowest index on a tie
        if (!rd_freed && (!have_best || rd_stamp < best_stamp)) begin
          have_best  <= 1'b1;
          best_idx   <= rd_idx;
          best_stamp <= rd_stamp;
        end
      end
    end
  end

  // commit decision
  logic [LIM_W-1:0]      limit;
  logic                  full;
  logic [STAMP_W-1:0]    stamp_inc;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [OWNER_BITS-1:0] wr_owner;
  logic [STATUS_W-1:0]   dec_status;
  logic                  dec_append;

  always_comb begin
    if (frames_in_use == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(frames_in_use) > LIM_MAX) begin
      limit = LIM_MAX;
    end else begin
      limit = LIM_W'(frames_in_use);
    end
  end

  assign full      = LIM_W'(fill_count) >= limit;
  assign stamp_inc = stamp_counter + 1'b1;

  always_comb begin
    wr_owner   = owner_q;
    dec_append = 1'b0;
    if (full && have_fr) begin
      wr_addr    = fr_idx;
      dec_status = STATUS_FILLED;
    end else if (have_hit) begin
      wr_addr    = hit_idx;
      wr_owner   = hit_owner;
      dec_status = STATUS_HIT;
    end else if (have_fr) begin
      wr_addr    = fr_idx;
      dec_status = STATUS_FILLED;
    end else if (!full) begin
      wr_addr    = fill_count[IDX_W-1:0];
      dec_append = 1'b1;
      dec_status = STATUS_APPEND;
    end else begin
      wr_addr    = best_idx;
      dec_status = STATUS_REPLACE;
    end
    wr_en = ctrl.commit && (req_q == REQ_ACCESS);
  end

  lft_entry_ram #(
    .DEPTH (NUM_FRAMES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({page_q, wr_owner, stamp_inc}),
    .rd_en   (ctrl.scan_issue),
    .rd_addr (scan_addr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // table state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      entry_freed   <= '0;
      stamp_counter <= '0;
    end else begin
      if (rd_vld && req_q == REQ_TERM && !rd_freed && rd_owner == owner_q) begin
        entry_freed[rd_idx] <= 1'b1;
      end
      if (wr_en) begin
        entry_freed[wr_addr] <= 1'b0;
        stamp_counter        <= stamp_inc;
        if (dec_append) fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_page <= page_q;
      if (req_q == REQ_TERM) begin
        res_status <= STATUS_TERM;
        res_frame  <= '0;
        res_freed  <= freed_cnt;
      end else begin
        res_status <= dec_status;
        res_frame  <= wr_addr;
        res_freed  <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.deliver) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deliver) begin
      status      <= res_status;
      frame_index <= res_frame;
      page_number <= res_page;
      freed_count <= res_freed;
    end
  end

endmodule

FILE: rtl/lft_checker.sv
module lft_checker #(
  parameter int NUM_FRAMES = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lft_pkg::STATUS_W-1:0]      status,
  input logic [$clog2(NUM_FRAMES)-1:0]     frame_index,
  input logic [lft_pkg::PAGE_W-1:0]        page_number,
  input logic [$clog2(NUM_FRAMES+1)-1:0]   freed_count
);

  import lft_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_index)
      && $stable(page_number) && $stable(freed_count))
    else $error("result beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in flight");

  a_term_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_TERM |-> frame_index == '0 && page_number == '0)
    else $error("terminate result carries frame or page");

  a_access_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_TERM |-> freed_count == '0)
    else $error("access result carries a freed count");

endmodule

bind lru_frame_table lft_checker #(.NUM_FRAMES(NUM_FRAMES)) u_lft_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .frame_index (frame_index),
  .page_number (page_number),
  .freed_count (freed_count)
);
